FILE: rtl/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types, widths, codes and saturation helpers for the 3-D natural
// cubic spline block.
// ----------------------------------------------------------------------------
package ncs_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 40;
  localparam int T_W     = 22;
  localparam int T_FRAC  = 16;
  localparam int SEG_W   = T_W - T_FRAC;

  // shared multiplier operand widths, sized for the widest fraction setting
  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = MUL_P_W + 2;
  localparam int SH_W    = 5;

  // shared divider widths
  localparam int DIV_N_W   = 49;
  localparam int DIV_D_W   = 27;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NO_CURVE = 1'b1;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic                      use_t;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [SUM_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[SUM_W-1:COEF_W-1];
    hi_zeros = ~|v[SUM_W-1:COEF_W-1];
    if (hi_ones || hi_zeros) return v[COEF_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(COEF_W-1){1'b0}}};
    else return {1'b0, {(COEF_W-1){1'b1}}};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[SUM_W-1:COORD_W-1];
    hi_zeros = ~|v[SUM_W-1:COORD_W-1];
    if (hi_ones || hi_zeros) return v[COORD_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(COORD_W-1){1'b0}}};
    else return {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

endpackage

FILE: rtl/ncs_mul.sv
// ----------------------------------------------------------------------------
// ncs_mul
// Shared signed multiplier with a registered product and a round-half-up
// shift by either the coefficient fraction or the parameter fraction.
// ----------------------------------------------------------------------------
module ncs_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  ncs_pkg::mul_req_t                req,
  output logic signed [ncs_pkg::MUL_P_W-1:0] rnd
);
  import ncs_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;
  logic                      use_t_r;
  logic [SH_W-1:0]           sh;
  logic signed [MUL_P_W-1:0] half;
  logic signed [MUL_P_W-1:0] biased;

  always_ff @(posedge clk) begin
    prod_r  <= MUL_P_W'(req.op_a) * MUL_P_W'(req.op_b);
    use_t_r <= req.use_t;
  end

  always_comb begin
    sh     = use_t_r ? SH_W'(T_FRAC) : SH_W'(FRAC_BITS);
    half   = MUL_P_W'(1) <<< (sh - SH_W'(1));
    biased = prod_r + half;
    rnd    = biased >>> sh;
  end

endmodule

FILE: rtl/ncs_div.sv
// ----------------------------------------------------------------------------
// ncs_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module ncs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ncs_pkg::div_req_t             req,
  output logic                          busy,
  output logic                          done,
  output logic [ncs_pkg::DIV_N_W-1:0]   quot
);
  import ncs_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   rem_nxt;
  logic [DIV_N_W-1:0]   quo_r;
  logic [DIV_D_W-1:0]   dvs_r;
  logic [DIV_D_W:0]     rem_sh;
  logic                 qbit;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_N_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_r});
    if (qbit) begin
      rem_nxt = DIV_D_W'(rem_sh - {1'b0, dvs_r});
    end else begin
      rem_nxt = rem_sh[DIV_D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_N_W);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_N_W-2:0], qbit};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: rtl/natural_cubic_spline_3d.sv
// Load word: stored as it is taken, while there is room. Evaluate word: three Horner
// steps per axis on the shared multiplier in turn, then the result word is emitted.
// Closing a set of n points: n-2 pivot divisions, then per axis forward and backward
// sweeps and the cubic and linear terms (divide by three as a seven-step shift-add).
// One word in flight at a time; stall stays high until it is done and emitted.
// Synchronous active-low reset clears control state; stores are not cleared.
// ----------------------------------------------------------------------------
// natural_cubic_spline_3d
// Natural cubic spline through uniformly spaced 3-D points: coefficient
// solve and Horner evaluation on a shared multiplier and divider.
// ----------------------------------------------------------------------------
module natural_cubic_spline_3d #(
  parameter int MAX_POINTS = ncs_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = ncs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic signed [ncs_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [ncs_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [ncs_pkg::COORD_W-1:0]  in_point_z,
  input  logic                                in_last_point,
  input  logic [ncs_pkg::T_W-1:0]             in_curve_param,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ncs_pkg::COORD_W-1:0]  out_value_x,
  output logic signed [ncs_pkg::COORD_W-1:0]  out_value_y,
  output logic signed [ncs_pkg::COORD_W-1:0]  out_value_z,
  output logic                                out_status
);
  import ncs_pkg::*;

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CMP_W = (CW > SEG_W) ? CW : SEG_W;
  localparam int RHS_W = COORD_W + 6;
  localparam int D3_W  = MUL_A_W + 1;

  typedef enum logic [5:0] {
    S_IDLE, S_PV_INIT, S_PV_LOOP, S_PV_DV,
    S_F_A0, S_F_A0W, S_F_A1, S_F_A1W, S_F_A1G, S_F_LOOP,
    S_F_W1, S_F_G1, S_F_W2, S_F_G2, S_F_M, S_F_S,
    S_B_INIT, S_B_LOOP, S_B_W, S_B_G, S_B_M, S_B_S,
    S_C_INIT, S_C_W0, S_C_G0, S_C_LOOP, S_C_W, S_C_G, S_C_DV, S_C_L,
    S_AXIS_END,
    S_EV_W, S_EV_M1, S_EV_A1, S_EV_M2, S_EV_A2, S_EV_M3, S_EV_A3,
    S_EMIT
  } state_t;

  state_t state_r;

  // stores, one bank per axis, and a single pivot store shared by the axes
  logic signed [COORD_W-1:0] pt_mem  [3][MAX_POINTS];
  logic signed [COEF_W-1:0]  sq_mem  [3][MAX_POINTS];
  logic signed [COEF_W-1:0]  cub_mem [3][MAX_POINTS];
  logic signed [COEF_W-1:0]  lin_mem [3][MAX_POINTS];
  logic [FRAC_BITS-1:0]      piv_mem [MAX_POINTS];

  logic signed [COORD_W-1:0] pt_rd  [3];
  logic signed [COEF_W-1:0]  sq_rd  [3];
  logic signed [COEF_W-1:0]  cub_rd [3];
  logic signed [COEF_W-1:0]  lin_rd [3];
  logic [FRAC_BITS-1:0]      piv_rd;

  logic [CW-1:0]             cnt_r;
  logic                      closed_r;
  logic                      ready_r;
  logic [1:0]                axis_r;
  logic [IW-1:0]             i_r;
  logic [IW-1:0]             rd_idx_r;
  logic [T_W-1:0]            dt_r;
  logic signed [COORD_W-1:0] a0_r;
  logic signed [COORD_W-1:0] a1_r;
  logic signed [COORD_W-1:0] a2_r;
  logic signed [COEF_W-1:0]  ccp_r;
  logic signed [COEF_W-1:0]  cc1_r;
  logic signed [COEF_W-1:0]  d_r;
  logic signed [COEF_W-1:0]  acc_r;
  logic                      neg_r;
  logic [FRAC_BITS-1:0]      wprev_r;
  logic signed [COORD_W-1:0] res_r [3];
  logic                      err_r;

  // divide by three, shift-add estimate then one correction
  logic [D3_W-1:0]           q3_n_r;
  logic [D3_W-1:0]           q3_r;
  logic [2:0]                q3_step_r;
  logic [4:0]                q3_rem_r;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic signed [COORD_W-1:0] out_z_r;
  logic                      out_status_r;

  // write ports
  logic                      pt_we;
  logic [IW-1:0]             pt_wa;
  logic                      sq_we;
  logic [IW-1:0]             sq_wa;
  logic signed [COEF_W-1:0]  sq_wd;
  logic                      cl_we;
  logic signed [COEF_W-1:0]  lin_wd;
  logic                      piv_we;

  // shared units
  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] mul_rnd;
  div_req_t                  div_req;
  logic                      div_busy;
  logic                      div_done;
  logic [DIV_N_W-1:0]        div_quot;

  // misc combinational
  logic [CW-1:0]             nseg;
  logic [CW-1:0]             cnt_eff;
  logic [CW-1:0]             cnt_new;
  logic                      has_room;
  logic [CMP_W-1:0]          seg_raw;
  logic [CMP_W-1:0]          seg_last;
  logic [CMP_W-1:0]          seg_cl;
  logic [T_W-1:0]            dt_new;
  logic signed [RHS_W-1:0]   rhs;
  logic signed [RHS_W-1:0]   rhs3;
  logic signed [MUL_A_W-1:0] fwd_diff;
  logic signed [MUL_A_W-1:0] cdiff;
  logic [MUL_A_W-1:0]        cabs;
  logic [DIV_D_W-1:0]        pivot_p;
  logic signed [SUM_W-1:0]   qext;
  logic signed [COEF_W-1:0]  fwd_cc;
  logic signed [COEF_W-1:0]  bwd_cc;
  logic                      in_acc;
  logic [5:0]                q3_sh;
  logic [D3_W-1:0]           q3_diff;
  logic [7:0]                q3_r11;
  logic [D3_W-1:0]           q3_fin;

  assign in_acc   = in_valid && !in_stall;
  assign nseg     = cnt_r - CW'(1);
  assign cnt_eff  = closed_r ? '0 : cnt_r;
  assign has_room = (cnt_eff < CW'(MAX_POINTS));
  assign cnt_new  = has_room ? cnt_eff + CW'(1) : cnt_eff;

  always_comb begin
    seg_raw  = CMP_W'(in_curve_param[T_W-1:T_FRAC]);
    seg_last = CMP_W'(cnt_r - CW'(2));
    seg_cl   = (seg_raw > seg_last) ? seg_last : seg_raw;
    dt_new   = in_curve_param - (T_W'(seg_cl) << T_FRAC);
  end

  always_comb begin
    rhs      = RHS_W'(a0_r) - (RHS_W'(a1_r) <<< 1) + RHS_W'(a2_r);
    rhs3     = rhs + (rhs <<< 1);
    fwd_diff = MUL_A_W'(rhs3) - MUL_A_W'(ccp_r);
    cdiff    = MUL_A_W'(sq_rd[axis_r]) - MUL_A_W'(ccp_r);
    cabs     = cdiff[MUL_A_W-1] ? MUL_A_W'(-cdiff) : MUL_A_W'(cdiff);
    pivot_p  = (DIV_D_W'(4) << FRAC_BITS) - DIV_D_W'(wprev_r);
    // estimate is low by a few, remainder stays below 32
    q3_sh    = 6'd2 << q3_step_r;
    q3_diff  = q3_n_r - (q3_r + (q3_r << 1));
    q3_r11   = {3'b0, q3_rem_r} + ({3'b0, q3_rem_r} << 1) + ({3'b0, q3_rem_r} << 3);
    q3_fin   = q3_r + D3_W'(q3_r11[7:5]);
    qext     = SUM_W'(q3_fin);
    fwd_cc   = sat_coef(SUM_W'(mul_rnd));
    bwd_cc   = sat_coef(SUM_W'(cc1_r) - SUM_W'(mul_rnd));
  end

  // shared unit requests, driven from the sequencer state ahead of the state that takes the product
  always_comb begin
    mul_req = '0;
    unique case (state_r)
      S_F_G2, S_F_M: begin
        mul_req.op_a = fwd_diff;
        mul_req.op_b = MUL_B_W'(piv_rd);
      end
      S_B_G, S_B_M: begin
        mul_req.op_a = MUL_A_W'(ccp_r);
        mul_req.op_b = MUL_B_W'(piv_rd);
      end
      S_EV_M1: begin
        mul_req.op_a  = MUL_A_W'(cub_rd[axis_r]);
        mul_req.op_b  = MUL_B_W'(dt_r);
        mul_req.use_t = 1'b1;
      end
      S_EV_M2, S_EV_M3: begin
        mul_req.op_a  = MUL_A_W'(acc_r);
        mul_req.op_b  = MUL_B_W'(dt_r);
        mul_req.use_t = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_PV_LOOP && CW'(i_r) != nseg) begin
      div_req.start    = 1'b1;
      div_req.dividend = (DIV_N_W'(1) << (2 * FRAC_BITS)) + DIV_N_W'(pivot_p >> 1);
      div_req.divisor  = pivot_p;
    end
  end

  ncs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .req (mul_req),
    .rnd (mul_rnd)
  );

  ncs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // store write controls
  always_comb begin
    pt_we  = in_acc && (in_req_type == REQ_LOAD) && has_room;
    pt_wa  = IW'(cnt_eff);
    sq_we  = 1'b0;
    sq_wa  = i_r;
    sq_wd  = '0;
    unique case (state_r)
      S_F_A0: begin
        sq_we = 1'b1;
        sq_wa = '0;
      end
      S_F_LOOP: begin
        sq_we = (CW'(i_r) == nseg);
        sq_wa = IW'(nseg);
      end
      S_F_S: begin
        sq_we = 1'b1;
        sq_wd = fwd_cc;
      end
      S_B_S: begin
        sq_we = 1'b1;
        sq_wd = bwd_cc;
      end
      default: ;
    endcase
    cl_we  = (state_r == S_C_L);
    lin_wd = sat_coef(SUM_W'(a1_r) - SUM_W'(a0_r) - SUM_W'(ccp_r) - SUM_W'(d_r));
    piv_we = (state_r == S_PV_DV) && div_done;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (pt_we) begin
        pt_mem[a][pt_wa] <= (a == 0) ? in_point_x : ((a == 1) ? in_point_y : in_point_z);
      end
      if (sq_we && axis_r == 2'(a)) begin
        sq_mem[a][sq_wa] <= sq_wd;
      end
      if (cl_we && axis_r == 2'(a)) begin
        cub_mem[a][i_r] <= d_r;
        lin_mem[a][i_r] <= lin_wd;
      end
      pt_rd[a]  <= pt_mem[a][rd_idx_r];
      sq_rd[a]  <= sq_mem[a][rd_idx_r];
      cub_rd[a] <= cub_mem[a][rd_idx_r];
      lin_rd[a] <= lin_mem[a][rd_idx_r];
    end
    if (piv_we) begin
      piv_mem[i_r] <= div_quot[FRAC_BITS-1:0];
    end
    piv_rd <= piv_mem[rd_idx_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      closed_r    <= 1'b0;
      ready_r     <= 1'b0;
      axis_r      <= '0;
      i_r         <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_req_type == REQ_LOAD) begin
              cnt_r    <= cnt_new;
              ready_r  <= 1'b0;
              closed_r <= in_last_point;
              if (in_last_point && cnt_new >= CW'(2)) begin
                state_r <= S_PV_INIT;
              end
            end else if (!ready_r) begin
              for (int a = 0; a < 3; a++) res_r[a] <= '0;
              err_r   <= ST_NO_CURVE;
              state_r <= S_EMIT;
            end else begin
              rd_idx_r <= IW'(seg_cl);
              dt_r     <= dt_new;
              axis_r   <= '0;
              err_r    <= ST_OK;
              state_r  <= S_EV_W;
            end
          end
        end

        // pivot reciprocals
        S_PV_INIT: begin
          i_r     <= IW'(1);
          wprev_r <= '0;
          state_r <= S_PV_LOOP;
        end
        S_PV_LOOP: begin
          if (CW'(i_r) == nseg) begin
            axis_r  <= '0;
            state_r <= S_F_A0;
          end else begin
            state_r <= S_PV_DV;
          end
        end
        S_PV_DV: begin
          if (div_done) begin
            wprev_r <= div_quot[FRAC_BITS-1:0];
            i_r     <= i_r + IW'(1);
            state_r <= S_PV_LOOP;
          end
        end

        // forward sweep
        S_F_A0: begin
          rd_idx_r <= '0;
          state_r  <= S_F_A0W;
        end
        S_F_A0W: state_r <= S_F_A1;
        S_F_A1: begin
          a0_r     <= pt_rd[axis_r];
          rd_idx_r <= IW'(1);
          state_r  <= S_F_A1W;
        end
        S_F_A1W: state_r <= S_F_A1G;
        S_F_A1G: begin
          a1_r    <= pt_rd[axis_r];
          i_r     <= IW'(1);
          ccp_r   <= '0;
          state_r <= S_F_LOOP;
        end
        S_F_LOOP: begin
          if (CW'(i_r) == nseg) begin
            state_r <= S_B_INIT;
          end else begin
            rd_idx_r <= i_r + IW'(1);
            state_r  <= S_F_W1;
          end
        end
        S_F_W1: state_r <= S_F_G1;
        S_F_G1: begin
          a2_r     <= pt_rd[axis_r];
          rd_idx_r <= i_r;
          state_r  <= S_F_W2;
        end
        S_F_W2: state_r <= S_F_G2;
        S_F_G2: state_r <= S_F_M;
        S_F_M:  state_r <= S_F_S;
        S_F_S: begin
          ccp_r   <= fwd_cc;
          a0_r    <= a1_r;
          a1_r    <= a2_r;
          i_r     <= i_r + IW'(1);
          state_r <= S_F_LOOP;
        end

        // backward sweep, ccp_r holds the term above
        S_B_INIT: begin
          i_r     <= IW'(nseg - CW'(1));
          ccp_r   <= '0;
          state_r <= S_B_LOOP;
        end
        S_B_LOOP: begin
          if (i_r == '0) begin
            state_r <= S_C_INIT;
          end else begin
            rd_idx_r <= i_r;
            state_r  <= S_B_W;
          end
        end
        S_B_W: state_r <= S_B_G;
        S_B_G: begin
          cc1_r   <= sq_rd[axis_r];
          state_r <= S_B_M;
        end
        S_B_M: state_r <= S_B_S;
        S_B_S: begin
          ccp_r   <= bwd_cc;
          i_r     <= i_r - IW'(1);
          state_r <= S_B_LOOP;
        end

        // cubic and linear terms
        S_C_INIT: begin
          i_r      <= '0;
          rd_idx_r <= '0;
          state_r  <= S_C_W0;
        end
        S_C_W0: state_r <= S_C_G0;
        S_C_G0: begin
          ccp_r   <= sq_rd[axis_r];
          a0_r    <= pt_rd[axis_r];
          state_r <= S_C_LOOP;
        end
        S_C_LOOP: begin
          if (CW'(i_r) == nseg) begin
            state_r <= S_AXIS_END;
          end else begin
            rd_idx_r <= i_r + IW'(1);
            state_r  <= S_C_W;
          end
        end
        S_C_W: state_r <= S_C_G;
        S_C_G: begin
          cc1_r     <= sq_rd[axis_r];
          a1_r      <= pt_rd[axis_r];
          neg_r     <= cdiff[MUL_A_W-1];
          q3_n_r    <= D3_W'(cabs) + D3_W'(1);
          q3_step_r <= '0;
          state_r   <= S_C_DV;
        end
        S_C_DV: begin
          q3_step_r <= q3_step_r + 3'd1;
          if (q3_step_r == 3'd0) begin
            q3_r <= (q3_n_r >> 2) + (q3_n_r >> 4);
          end else if (q3_step_r < 3'd5) begin
            q3_r <= q3_r + (q3_r >> q3_sh);
          end else if (q3_step_r == 3'd5) begin
            q3_rem_r <= q3_diff[4:0];
          end else begin
            d_r     <= sat_coef(neg_r ? -qext : qext);
            state_r <= S_C_L;
          end
        end
        S_C_L: begin
          ccp_r   <= cc1_r;
          a0_r    <= a1_r;
          i_r     <= i_r + IW'(1);
          state_r <= S_C_LOOP;
        end

        S_AXIS_END: begin
          if (axis_r == 2'd2) begin
            ready_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_F_A0;
          end
        end

        // horner evaluation, one axis at a time
        S_EV_W:  state_r <= S_EV_M1;
        S_EV_M1: state_r <= S_EV_A1;
        S_EV_A1: begin
          acc_r   <= sat_coef(SUM_W'(mul_rnd) + SUM_W'(sq_rd[axis_r]));
          state_r <= S_EV_M2;
        end
        S_EV_M2: state_r <= S_EV_A2;
        S_EV_A2: begin
          acc_r   <= sat_coef(SUM_W'(mul_rnd) + SUM_W'(lin_rd[axis_r]));
          state_r <= S_EV_M3;
        end
        S_EV_M3: state_r <= S_EV_A3;
        S_EV_A3: begin
          res_r[axis_r] <= sat_coord(SUM_W'(mul_rnd) + SUM_W'(pt_rd[axis_r]));
          if (axis_r == 2'd2) begin
            state_r <= S_EMIT;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_EV_M1;
          end
        end

        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_x_r      <= res_r[0];
            out_y_r      <= res_r[1];
            out_z_r      <= res_r[2];
            out_status_r <= err_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_value_x = out_x_r;
  assign out_value_y = out_y_r;
  assign out_value_z = out_z_r;
  assign out_status  = out_status_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_ready_set: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (closed_r && cnt_r >= CW'(2)))
    else $error("curve ready without a closed set of two points");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_NO_CURVE) |->
      (out_x_r == '0 && out_y_r == '0 && out_z_r == '0))
    else $error("error word carries non-zero values");

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("result word lost on emit");

endmodule

FILE: verif/tb_natural_cubic_spline_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_natural_cubic_spline_3d
// Drives load and evaluate words into the spline block under random idling
// and back-pressure. A cycle-free model of the coefficient solve and the
// Horner evaluation predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_natural_cubic_spline_3d;
  import ncs_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int FB   = FRAC_BITS_DEF;
  localparam longint C40_HI = 64'sd549755813887;
  localparam longint C40_LO = -64'sd549755813888;

  typedef struct {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic                      st;
  } curve_value_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = REQ_LOAD;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic in_last_point = 1'b0;
  logic [T_W-1:0] in_curve_param = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_value_x;
  logic signed [COORD_W-1:0] out_value_y;
  logic signed [COORD_W-1:0] out_value_z;
  logic out_status;

  natural_cubic_spline_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_last_point(in_last_point), .in_curve_param(in_curve_param),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value_x(out_value_x), .out_value_y(out_value_y), .out_value_z(out_value_z),
    .out_status(out_status)
  );

  always #1 clk = ~clk;

  // shadow of the spline state
  longint knot_pos [3][NPTS];
  longint lin_c    [3][NPTS];
  longint sq_c     [3][NPTS];
  longint cub_c    [3][NPTS];
  longint pivot_w  [NPTS];
  int     knots_held;
  bit     curve_ok;
  bit     set_done;

  curve_value_t expected_values_q[$];
  int mismatches = 0;
  int words_sent = 0;
  int loads_sent = 0;
  int evals_sent = 0;
  int sets_solved = 0;
  int values_seen = 0;
  bit quiet = 1'b0;
  int long_hold = 0;

  function automatic longint sat40(longint v);
    return v < C40_LO ? C40_LO : (v > C40_HI ? C40_HI : v);
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint third_rounded(longint v);
    if (v >= 0) return (v + 1) / 3;
    return -((-v + 1) / 3);
  endfunction

  task automatic solve_curve();
    longint cc[NPTS];
    longint p;
    longint d;
    int nseg;
    nseg = knots_held - 1;
    if (knots_held < 2) begin
      curve_ok = 1'b0;
      return;
    end
    pivot_w[0] = 0;
    for (int i = 1; i + 1 < knots_held; i++) begin
      p = (64'sd4 <<< FB) - pivot_w[i-1];
      pivot_w[i] = ((64'sd1 <<< (2*FB)) + p / 2) / p;
    end
    for (int ax = 0; ax < 3; ax++) begin
      for (int i = 0; i < NPTS; i++) cc[i] = 0;
      for (int i = 1; i < nseg; i++)
        cc[i] = 3 * (knot_pos[ax][i-1] - 2 * knot_pos[ax][i] + knot_pos[ax][i+1]);
      for (int i = 1; i < nseg; i++)
        cc[i] = sat40(round_sh((cc[i] - cc[i-1]) * pivot_w[i], FB));
      for (int i = nseg - 1; i > 0; i--)
        cc[i] = sat40(cc[i] - round_sh(cc[i+1] * pivot_w[i], FB));
      for (int i = 0; i <= nseg; i++) sq_c[ax][i] = cc[i];
      for (int i = 0; i < nseg; i++) begin
        d = sat40(third_rounded(cc[i+1] - cc[i]));
        cub_c[ax][i] = d;
        lin_c[ax][i] = sat40(knot_pos[ax][i+1] - knot_pos[ax][i] - cc[i] - d);
      end
    end
    curve_ok = 1'b1;
    sets_solved++;
  endtask

  // applies one accepted word to the shadow state, queues any result
  task automatic spline_predict_word(logic rq, longint px, longint py, longint pz,
                                     logic lastp, longint tp);
    curve_value_t ev;
    longint seg;
    longint dt;
    longint r;
    longint res[3];
    if (rq == REQ_LOAD) begin
      if (set_done) begin
        knots_held = 0;
        curve_ok = 1'b0;
        set_done = 1'b0;
      end
      if (knots_held < NPTS) begin
        knot_pos[0][knots_held] = px;
        knot_pos[1][knots_held] = py;
        knot_pos[2][knots_held] = pz;
        knots_held++;
      end
      if (lastp) begin
        set_done = 1'b1;
        solve_curve();
      end
      return;
    end
    if (!curve_ok || knots_held < 2) begin
      ev.vx = '0; ev.vy = '0; ev.vz = '0; ev.st = ST_NO_CURVE;
    end else begin
      seg = tp >>> T_FRAC;
      if (seg > knots_held - 2) seg = knots_held - 2;
      dt = tp - (seg <<< T_FRAC);
      for (int ax = 0; ax < 3; ax++) begin
        r = cub_c[ax][seg];
        r = sat40(round_sh(r * dt, T_FRAC) + sq_c[ax][seg]);
        r = sat40(round_sh(r * dt, T_FRAC) + lin_c[ax][seg]);
        r = round_sh(r * dt, T_FRAC) + knot_pos[ax][seg];
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        res[ax] = r;
      end
      ev.vx = res[0][31:0]; ev.vy = res[1][31:0]; ev.vz = res[2][31:0];
      ev.st = ST_OK;
    end
    expected_values_q.push_back(ev);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offers one word and waits until the block takes it
  task automatic send_word(logic rq, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic lastp, logic [T_W-1:0] tp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rq;
    in_point_x     <= px;
    in_point_y     <= py;
    in_point_z     <= pz;
    in_last_point  <= lastp;
    in_curve_param <= tp;
    do @(posedge clk); while (in_stall);
    spline_predict_word(rq, longint'($signed(px)), longint'($signed(py)),
                        longint'($signed(pz)), lastp, longint'(tp));
    words_sent++;
    if (rq == REQ_LOAD) loads_sent++;
    else evals_sent++;
  endtask

  task automatic load_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic lastp);
    send_word(REQ_LOAD, px, py, pz, lastp, T_W'($urandom()));
  endtask

  task automatic eval_at(logic [T_W-1:0] tp);
    send_word(REQ_EVAL, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)), tp);
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    if (r < 8) return $urandom();
    return r == 8 ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  // receiver: short random stalls, occasional long ones, forced hold-off on request
  int stall_left = 0;
  always @(posedge clk) begin
    if (long_hold > 0) begin
      stall_left = long_hold;
      long_hold = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet) begin
        automatic int r = $urandom_range(0, 99);
        if (r < 3) stall_left = $urandom_range(15, 50);
        else if (r < 25) stall_left = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      values_seen++;
      if (expected_values_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: x=%h y=%h z=%h st=%b",
                                       out_value_x, out_value_y, out_value_z, out_status);
      end else begin
        automatic curve_value_t ev = expected_values_q.pop_front();
        if (ev.vx !== out_value_x || ev.vy !== out_value_y || ev.vz !== out_value_z ||
            ev.st !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h st=%b got x=%h y=%h z=%h st=%b",
                     ev.vx, ev.vy, ev.vz, ev.st,
                     out_value_x, out_value_y, out_value_z, out_status);
        end
      end
    end
  end

  task automatic test_no_curve();
    eval_at('0);
    eval_at('1);
    load_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
    eval_at(22'h01_0000);
  endtask

  task automatic test_directed();
    load_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 1'b0);
    eval_at(22'h00_8000);
    load_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
    eval_at('0);
    eval_at(22'h00_8000);
    eval_at(22'h01_0000);
    eval_at('1);
    load_point(32'h0000_0000, 32'h0001_0000, 32'hfff0_0000, 1'b0);
    load_point(32'h7fff_ffff, 32'h8000_0000, 32'h0010_0000, 1'b0);
    load_point(32'h0000_0000, 32'h0001_0000, 32'hfff0_0000, 1'b0);
    load_point(32'h8000_0000, 32'h7fff_ffff, 32'h0010_0000, 1'b1);
    eval_at(22'h00_4000);
    eval_at(22'h01_c000);
    eval_at(22'h02_ffff);
    eval_at(22'h03_0000);
    eval_at('1);
  endtask

  task automatic test_capacity();
    for (int i = 0; i < NPTS + 6; i++)
      load_point(rand_coord(), rand_coord(), rand_coord(), i == NPTS + 5);
    eval_at(22'((NPTS - 2) << T_FRAC) + 22'h8000);
    eval_at(22'((NPTS - 1) << T_FRAC));
    eval_at(T_W'($urandom()));
    // a set closed with the flag on a word that still fits
    for (int i = 0; i < NPTS; i++)
      load_point(rand_coord(), rand_coord(), rand_coord(), i == NPTS - 1);
    eval_at(22'($urandom_range(0, NPTS << T_FRAC)));
  endtask

  task automatic test_backpressure();
    load_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
    load_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
    load_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
    long_hold = 400;
    for (int i = 0; i < 8; i++) eval_at(22'($urandom_range(0, 3 << T_FRAC)));
  endtask

  task automatic test_random(int target);
    int n;
    int r;
    while (words_sent < target) begin
      quiet = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 19);
      n = (r == 0) ? 1 : (r < 3 ? $urandom_range(9, 20) : $urandom_range(2, 8));
      for (int i = 0; i < n; i++) begin
        load_point(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
        // evaluate inside an open set now and then
        if (i < n - 1 && $urandom_range(0, 15) == 0) eval_at(T_W'($urandom()));
      end
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 4) == 0) eval_at(T_W'($urandom()));
        else eval_at(22'($urandom_range(0, n << T_FRAC)));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    knots_held = 0;
    curve_ok = 1'b0;
    set_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_curve();
    test_directed();
    test_capacity();
    test_backpressure();
    test_random(1700);
    in_valid <= 1'b0;
    while (expected_values_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d words: %0d loads, %0d evaluates, %0d curves solved",
             words_sent, loads_sent, evals_sent, sets_solved);
    $display("%0d results checked, %0d mismatches", values_seen, mismatches);
    if (mismatches == 0 && expected_values_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", expected_values_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
